>>> src/rgfd_pkg.sv
// Shared types and constants for the silence-gap frame delimiter.
`timescale 1ns / 1ps
`default_nettype none

package rgfd_pkg;

  // Register reset values
  localparam logic [15:0] GAP_LIMIT_RST     = 16'd1500;
  localparam logic [15:0] FRAME_TIMEOUT_RST = 16'd3500;

  // Register indexes on the config port
  localparam logic [7:0] CFG_IDX_GAP_LIMIT     = 8'd0;
  localparam logic [7:0] CFG_IDX_FRAME_TIMEOUT = 8'd1;

  // Write position limits
  localparam logic [7:0] FULL_POSITION = 8'd255;
  localparam logic [7:0] LAST_SLOT     = 8'd254;

  // Input command codes
  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_BYTE = 1'b1;

  typedef enum logic {
    EV_BYTE      = 1'b0,
    EV_FRAME_END = 1'b1
  } event_kind_t;

  typedef struct packed {
    event_kind_t event_kind;
    logic [7:0]  slot;
    logic [7:0]  byte_out;
    logic [7:0]  frame_length;
  } result_t;

endpackage : rgfd_pkg

`default_nettype wire

>>> src/rgfd_core.sv
// Silence counter and write position tracking; produces at most one event per word.
`timescale 1ns / 1ps
`default_nettype none

module rgfd_core (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             accept,
  input  wire logic             cmd,
  input  wire logic [7:0]       rx_byte,
  input  wire logic [15:0]      gap_limit,
  input  wire logic [15:0]      frame_timeout,
  output logic                  res_valid,
  output rgfd_pkg::result_t     res
);
  import rgfd_pkg::*;

  logic [15:0] count_r, count_nxt;
  logic        running_r, running_nxt;
  logic [7:0]  pos_r, pos_nxt;

  logic [7:0]  pos_base;
  logic [7:0]  slot;
  logic [16:0] count_inc;
  logic        timeout_hit;

  // Byte path: restart frame after a long gap, clamp a full frame to the last slot
  assign pos_base    = (count_r > gap_limit) ? 8'd0 : pos_r;
  assign slot        = (pos_base == FULL_POSITION) ? LAST_SLOT : pos_base;
  // Tick path: 17-bit increment so a full count still compares correctly
  assign count_inc   = {1'b0, count_r} + 17'd1;
  assign timeout_hit = count_inc >= {1'b0, frame_timeout};

  // Next state and result
  always_comb begin
    count_nxt   = count_r;
    running_nxt = running_r;
    pos_nxt     = pos_r;
    res_valid   = 1'b0;
    res         = '{event_kind: EV_BYTE, slot: 8'd0, byte_out: 8'd0, frame_length: 8'd0};
    if (accept) begin
      if (cmd == CMD_BYTE) begin
        count_nxt        = 16'd0;
        running_nxt      = 1'b1;
        pos_nxt          = slot + 8'd1;
        res_valid        = 1'b1;
        res.slot         = slot;
        res.byte_out     = rx_byte;
      end else if (running_r) begin
        if (timeout_hit) begin
          count_nxt   = 16'd0;
          running_nxt = 1'b0;
          pos_nxt     = 8'd0;
          if (pos_r != 8'd0) begin
            res_valid        = 1'b1;
            res.event_kind   = EV_FRAME_END;
            res.frame_length = pos_r;
          end
        end else begin
          count_nxt = count_inc[15:0];
        end
      end
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= 16'd0;
      running_r <= 1'b1;
      pos_r     <= 8'd0;
    end else begin
      count_r   <= count_nxt;
      running_r <= running_nxt;
      pos_r     <= pos_nxt;
    end
  end

  // A stopped timer always holds a zero count
  a_stopped_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !running_r |-> count_r == 16'd0)
    else $error("silence count nonzero while timer stopped");

  // A stored byte never lands beyond the last slot
  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res.event_kind == EV_BYTE |-> res.slot <= LAST_SLOT)
    else $error("byte slot out of range");

  // A received byte always restarts the timer and leaves a nonzero position
  a_byte_restart: assert property (@(posedge clk) disable iff (!rst_n)
    accept && cmd == CMD_BYTE |=> running_r && count_r == 16'd0 && pos_r != 8'd0)
    else $error("byte did not restart timer");

  // A frame end always reports a nonzero length and clears the position
  a_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res.event_kind == EV_FRAME_END |=> !running_r && pos_r == 8'd0)
    else $error("frame end left state inconsistent");

endmodule : rgfd_core

`default_nettype wire

>>> src/rtu_gap_frame_delimiter_unit.sv
// Top level: config registers, delimiter core and output register with skid stage.
// Each core result is registered into the output register, or the skid if stalled.
// Throughput: one word per cycle unless stalled; core is a single registered pass.
// A two-entry output stage (output register plus skid) absorbs one stalled result.
// Reset (rst_n low, synchronous): timer running, count and position zero,
// gap_limit = 1500, frame_timeout = 3500, output and skid empty.
`timescale 1ns / 1ps
`default_nettype none

module rtu_gap_frame_delimiter_unit (
  input  wire logic       clk,
  input  wire logic       rst_n,
  // input channel
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic       in_cmd,
  input  wire logic [7:0] in_rx_byte,
  // result channel
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic            out_event_kind,
  output logic [7:0]      out_slot,
  output logic [7:0]      out_byte_out,
  output logic [7:0]      out_frame_length,
  // config channel
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [7:0] cfg_index,
  input  wire logic [15:0] cfg_data
);
  import rgfd_pkg::*;

  logic [15:0] gap_limit_r;
  logic [15:0] frame_timeout_r;

  logic        in_accept;
  logic        res_valid;
  result_t     res;

  logic        out_valid_r, out_valid_nxt;
  result_t     out_data_r, out_data_nxt;
  logic        skid_valid_r, skid_valid_nxt;
  result_t     skid_data_r, skid_data_nxt;
  logic        out_free;

  // Config writes are always taken
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_limit_r     <= GAP_LIMIT_RST;
      frame_timeout_r <= FRAME_TIMEOUT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_IDX_GAP_LIMIT:     gap_limit_r     <= cfg_data;
        CFG_IDX_FRAME_TIMEOUT: frame_timeout_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input side stalls only when the skid holds a word
  assign in_stall  = skid_valid_r;
  assign in_accept = in_valid && !in_stall;

  rgfd_core u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (in_accept),
    .cmd           (in_cmd),
    .rx_byte       (in_rx_byte),
    .gap_limit     (gap_limit_r),
    .frame_timeout (frame_timeout_r),
    .res_valid     (res_valid),
    .res           (res)
  );

  // Output register and skid stage
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (out_free) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = res_valid;
        skid_data_nxt  = res;
      end else begin
        out_valid_nxt  = res_valid;
        out_data_nxt   = res;
      end
    end else if (res_valid) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_event_kind   = out_data_r.event_kind;
  assign out_slot         = out_data_r.slot;
  assign out_byte_out     = out_data_r.byte_out;
  assign out_frame_length = out_data_r.frame_length;

  // Skid only fills behind a held output word
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid word without output word");

  // A new result never arrives while the skid is full
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> !res_valid)
    else $error("result dropped on full skid");

  // A result of the core shows at the output or in the skid on the next cycle
  a_result_kept: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |=> out_valid_r)
    else $error("result lost");

endmodule : rtu_gap_frame_delimiter_unit

`default_nettype wire
